// File: hdl/dmarx_pkg.sv
// Shared types, codes and sizes for the receive DMA channel.
// No dependencies; every other file in hdl/ imports this package.
package dmarx_pkg;

    localparam int QUEUE_SLOTS = 2;
    localparam int SIZE_BITS   = 20;

    localparam int QCNT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int QIDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int REM_W  = SIZE_BITS + 1;

    // Request types.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_PUSH  = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_CFG   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // Config register bit positions.
    localparam int CFG_CONT_BIT  = 0;
    localparam int CFG_DSIZE_LO  = 1;
    localparam int CFG_EN_BIT    = 4;
    localparam int CFG_PEND_BIT  = 5;
    localparam int CFG_CLR_BIT   = 6;

    localparam logic [2:0] WORD_BYTES = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  reg_index;
        logic [31:0] write_value;
        logic [31:0] push_bytes;
        logic [2:0]  push_count;
    } req_t;

    typedef struct packed {
        logic [31:0]               start_addr;
        logic [SIZE_BITS-1:0]      size;
        logic                      continuous;
        logic [1:0]                dsize_code;
        logic [QCNT_W-1:0]         queued;
        logic                      active;
        logic [31:0]               xfer_addr;
        logic signed [REM_W-1:0]   remaining;
        logic [31:0]               packing_word;
        logic [2:0]                packing_index;
    } state_t;

    typedef struct packed {
        logic [QUEUE_SLOTS-1:0][31:0]          addr;
        logic [QUEUE_SLOTS-1:0][SIZE_BITS-1:0] size;
    } slots_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        mem_write_valid;
        logic [31:0] mem_write_addr;
        logic [31:0] mem_write_word;
        logic        transfer_end;
    } result_t;

endpackage

// File: hdl/dmarx_step.sv
// Next-state and result logic for one request of the receive DMA channel.
// Depends on dmarx_pkg.
module dmarx_step (
    input  dmarx_pkg::req_t    req,
    input  dmarx_pkg::state_t  cur_state,
    input  dmarx_pkg::slots_t  cur_slots,
    output dmarx_pkg::state_t  state_next,
    output dmarx_pkg::slots_t  slots_next,
    output dmarx_pkg::result_t result
);
    import dmarx_pkg::*;

    logic [QCNT_W:0]          busy;
    logic                     do_promote;
    logic [3:0]               idx_sum;
    logic [4:0]               byte_shift;
    logic [3:0]               byte_en;
    logic [31:0]              bit_mask;
    logic [31:0]              mask_sh;
    logic [31:0]              data_sh;
    logic [31:0]              word_new;
    logic signed [REM_W-1:0]  idx_ext;
    logic signed [REM_W-1:0]  rem_dec;

    assign busy       = {1'b0, cur_state.queued} + {{QCNT_W{1'b0}}, cur_state.active};
    assign idx_sum    = {1'b0, cur_state.packing_index} + {1'b0, req.push_count};
    assign byte_shift = {cur_state.packing_index[1:0], 3'b000};
    assign idx_ext    = $signed({{(REM_W-3){1'b0}}, idx_sum[2:0]});
    assign rem_dec    = cur_state.remaining - REM_W'(signed'(4));

    always_comb
    begin
        case (req.push_count)
            3'd1:    byte_en = 4'b0001;
            3'd2:    byte_en = 4'b0011;
            3'd3:    byte_en = 4'b0111;
            3'd4:    byte_en = 4'b1111;
            default: byte_en = 4'b0000;
        endcase
        for (int b = 0; b < 4; b++)
        begin
            bit_mask[8*b +: 8] = {8{byte_en[b]}};
        end
    end

    assign mask_sh  = bit_mask << byte_shift;
    assign data_sh  = req.push_bytes << byte_shift;
    assign word_new = (cur_state.packing_word & ~mask_sh) | (data_sh & mask_sh);

    always_comb
    begin
        state_next = cur_state;
        slots_next = cur_slots;
        result     = '0;
        do_promote = 1'b0;

        case (req.req_type)
            REQ_READ:
            begin
                case (req.reg_index)
                    REG_START: result.read_value = cur_state.start_addr;
                    REG_SIZE:  result.read_value = 32'(cur_state.size);
                    REG_CFG:
                    begin
                        result.read_value[CFG_CONT_BIT]             = cur_state.continuous;
                        result.read_value[CFG_DSIZE_LO +: 2]        = cur_state.dsize_code;
                        result.read_value[CFG_EN_BIT]               = (busy != '0);
                        result.read_value[CFG_PEND_BIT]             =
                            (busy >= (QCNT_W+1)'(QUEUE_SLOTS));
                    end
                    default:   result.status = ST_INVALID;
                endcase
            end
            REQ_WRITE:
            begin
                case (req.reg_index)
                    REG_START: state_next.start_addr = req.write_value;
                    REG_SIZE:  state_next.size = req.write_value[SIZE_BITS-1:0];
                    REG_CFG:
                    begin
                        state_next.continuous = req.write_value[CFG_CONT_BIT];
                        state_next.dsize_code = req.write_value[CFG_DSIZE_LO +: 2];
                        if (req.write_value[CFG_CLR_BIT])
                        begin
                            result.status = ST_INVALID;
                        end
                        else if (req.write_value[CFG_EN_BIT])
                        begin
                            if ((busy >= (QCNT_W+1)'(QUEUE_SLOTS)) ||
                                (cur_state.queued >= QCNT_W'(QUEUE_SLOTS)))
                            begin
                                result.status = ST_IGNORED;
                            end
                            else
                            begin
                                slots_next.addr[cur_state.queued[QIDX_W-1:0]] =
                                    cur_state.start_addr;
                                slots_next.size[cur_state.queued[QIDX_W-1:0]] =
                                    cur_state.size;
                                state_next.queued = cur_state.queued + 1'b1;
                                do_promote = 1'b1;
                            end
                        end
                    end
                    default:   result.status = ST_INVALID;
                endcase
            end
            REQ_PUSH:
            begin
                if (!cur_state.active || (req.push_count == 3'd0) ||
                    (idx_sum > 4'(WORD_BYTES)))
                begin
                    result.status = ST_IGNORED;
                end
                else
                begin
                    state_next.packing_word  = word_new;
                    state_next.packing_index = idx_sum[2:0];
                    if ((idx_sum[2:0] >= WORD_BYTES) || (idx_ext >= cur_state.remaining))
                    begin
                        state_next.packing_index = 3'd0;
                        result.mem_write_valid   = 1'b1;
                        result.mem_write_addr    = {cur_state.xfer_addr[31:2], 2'b00};
                        result.mem_write_word    = word_new;
                        state_next.xfer_addr     = cur_state.xfer_addr + 32'd4;
                        state_next.remaining     = rem_dec;
                        if (rem_dec <= 0)
                        begin
                            result.transfer_end  = 1'b1;
                            state_next.active    = 1'b0;
                            state_next.remaining = '0;
                            do_promote           = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                result.status = ST_INVALID;
            end
        endcase

        // A pending transfer becomes current as soon as the channel is free.
        if (do_promote && !state_next.active && (state_next.queued != '0))
        begin
            state_next.xfer_addr = slots_next.addr[0];
            state_next.remaining = $signed({1'b0, slots_next.size[0]});
            state_next.active    = 1'b1;
            state_next.queued    = state_next.queued - 1'b1;
            for (int k = 0; k + 1 < QUEUE_SLOTS; k++)
            begin
                slots_next.addr[k] = slots_next.addr[k+1];
                slots_next.size[k] = slots_next.size[k+1];
            end
        end
    end

endmodule

// File: hdl/dma_rx_channel_with_transfer_queue_core.sv
// Top level of the receive DMA channel: beat registers, channel state, result register.
// Depends on dmarx_pkg and dmarx_step.

// One receive DMA channel. Each input beat is a register read, a register
// write or a push of one to four peripheral bytes, and each produces exactly
// one result beat carrying a status, read data and, for pushes, an optional
// memory write of a packed little-endian word plus an end-of-transfer flag.
// Writing the config register with the enable bit set queues a transfer from
// the start address and size registers; it starts at once when the channel is
// idle. The block takes one beat per clock cycle unless its input stalls: a
// beat is captured in an input register, the step logic updates the channel
// state from it, and the result is written to an output register when the
// beat moves on. A stalled output holds the result register, and the input
// stalls only when the input register holds a beat while the result register
// is full and its output is stalled.
module dma_rx_channel_with_transfer_queue_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [1:0]  reg_index,
    input  logic [31:0] write_value,
    input  logic [31:0] push_bytes,
    input  logic [2:0]  push_count,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic        mem_write_valid,
    output logic [31:0] mem_write_addr,
    output logic [31:0] mem_write_word,
    output logic        transfer_end
);
    import dmarx_pkg::*;

    req_t    req_reg;
    logic    req_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    slots_t  slots_reg;
    slots_t  slots_next;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;

    logic    in_take;
    logic    advance;

    // The held beat moves on whenever the result register is empty or draining.
    assign advance  = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    dmarx_step u_step (
        .req        (req_reg),
        .cur_state  (state_reg),
        .cur_slots  (slots_reg),
        .state_next (state_next),
        .slots_next (slots_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; the queue slots are only read after being written.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.req_type    <= req_type;
            req_reg.reg_index   <= reg_index;
            req_reg.write_value <= write_value;
            req_reg.push_bytes  <= push_bytes;
            req_reg.push_count  <= push_count;
        end
        if (advance)
        begin
            slots_reg <= slots_next;
            res_reg   <= res_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign status          = res_reg.status;
    assign read_value      = res_reg.read_value;
    assign mem_write_valid = res_reg.mem_write_valid;
    assign mem_write_addr  = res_reg.mem_write_addr;
    assign mem_write_word  = res_reg.mem_write_word;
    assign transfer_end    = res_reg.transfer_end;

endmodule

// File: dv/dma_rx_channel_with_transfer_queue_core_test.sv
// Self-checking test of the receive DMA channel: directed beats, then random transfers.
// Depends on dmarx_pkg and dma_rx_channel_with_transfer_queue_core from hdl/.
`timescale 1ns / 100ps

module dma_rx_channel_with_transfer_queue_core_test;

    import dmarx_pkg::*;

    // The package names three request types and three registers; the fourth
    // code of each is an illegal access.
    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam logic [1:0] REG_BAD = 2'd3;

    localparam int BEAT_TARGET = 1200;

    // Channel predictor and result scoreboard. Every accepted request beat is
    // run through a private copy of the channel state, and the result it owes
    // is queued. Every accepted result beat is checked against the oldest one.
    class rx_channel_scoreboard;
        logic [31:0]          start_addr;
        logic [SIZE_BITS-1:0] size_val;
        logic                 cont;
        logic [1:0]           dsize;
        logic [31:0]          slot_addr [QUEUE_SLOTS];
        logic [SIZE_BITS-1:0] slot_size [QUEUE_SLOTS];
        int                   queued;
        bit                   active;
        logic [31:0]          cur_addr;
        longint               remaining;
        logic [31:0]          pack_word;
        int                   pack_idx;
        result_t              owed[$];
        int                   errors;

        function new();
            start_addr = '0;
            size_val   = '0;
            cont       = 1'b0;
            dsize      = '0;
            queued     = 0;
            active     = 1'b0;
            cur_addr   = '0;
            remaining  = 0;
            pack_word  = '0;
            pack_idx   = 0;
            errors     = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Moves the oldest queued transfer into the current one when the
        // channel has nothing active.
        function void start_next();
            if (active || queued == 0)
                return;
            cur_addr  = slot_addr[0];
            remaining = slot_size[0];
            active    = 1'b1;
            for (int k = 0; k + 1 < QUEUE_SLOTS; k++)
            begin
                slot_addr[k] = slot_addr[k + 1];
                slot_size[k] = slot_size[k + 1];
            end
            queued--;
        endfunction

        function logic [1:0] queue_transfer();
            if (queued + int'(active) >= QUEUE_SLOTS || queued >= QUEUE_SLOTS)
                return ST_IGNORED;
            slot_addr[queued] = start_addr;
            slot_size[queued] = size_val;
            queued++;
            start_next();
            return ST_OK;
        endfunction

        // Updates the predicted state for one request and queues its result.
        function void note_request(logic [1:0] rt, logic [1:0] ri, logic [31:0] wv,
                                   logic [31:0] bytes, logic [2:0] cnt);
            result_t r;
            int      busy;
            int      pos;
            r = '0;
            busy = queued + int'(active);
            case (rt)
                REQ_READ:
                begin
                    case (ri)
                        REG_START: r.read_value = start_addr;
                        REG_SIZE:  r.read_value = 32'(size_val);
                        REG_CFG:
                        begin
                            r.read_value[CFG_CONT_BIT]      = cont;
                            r.read_value[CFG_DSIZE_LO +: 2] = dsize;
                            r.read_value[CFG_EN_BIT]        = (busy != 0);
                            r.read_value[CFG_PEND_BIT]      = (busy >= QUEUE_SLOTS);
                        end
                        default:   r.status = ST_INVALID;
                    endcase
                end
                REQ_WRITE:
                begin
                    case (ri)
                        REG_START: start_addr = wv;
                        REG_SIZE:  size_val = wv[SIZE_BITS-1:0];
                        REG_CFG:
                        begin
                            cont  = wv[CFG_CONT_BIT];
                            dsize = wv[CFG_DSIZE_LO +: 2];
                            if (wv[CFG_CLR_BIT])
                                r.status = ST_INVALID;
                            else if (wv[CFG_EN_BIT])
                                r.status = queue_transfer();
                        end
                        default:   r.status = ST_INVALID;
                    endcase
                end
                REQ_PUSH:
                begin
                    if (!active || cnt == 0 || pack_idx + int'(cnt) > int'(WORD_BYTES))
                        r.status = ST_IGNORED;
                    else
                    begin
                        for (int k = 0; k < int'(cnt); k++)
                        begin
                            pos = (pack_idx + k) % 4;
                            pack_word[8*pos +: 8] = bytes[8*k +: 8];
                        end
                        pack_idx += int'(cnt);
                        // A word goes out when it is full or when it covers
                        // what is left of the transfer.
                        if (pack_idx >= int'(WORD_BYTES) || pack_idx >= remaining)
                        begin
                            pack_idx          = 0;
                            r.mem_write_valid = 1'b1;
                            r.mem_write_addr  = {cur_addr[31:2], 2'b00};
                            r.mem_write_word  = pack_word;
                            cur_addr          = cur_addr + 32'd4;
                            remaining         = remaining - 4;
                            if (remaining <= 0)
                            begin
                                r.transfer_end = 1'b1;
                                active         = 1'b0;
                                remaining      = 0;
                                start_next();
                            end
                        end
                    end
                end
                default: r.status = ST_INVALID;
            endcase
            owed.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 100)
                $display("[%0t] %s: got %h, want %h", $time, what, got, want);
        endtask

        task check_result(result_t got);
            result_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("result beat with nothing owed", 32'(got.status), '0);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
            if (got.mem_write_valid !== want.mem_write_valid)
                report_mismatch("mem_write_valid", 32'(got.mem_write_valid),
                                32'(want.mem_write_valid));
            if (got.mem_write_addr !== want.mem_write_addr)
                report_mismatch("mem_write_addr", got.mem_write_addr, want.mem_write_addr);
            if (got.mem_write_word !== want.mem_write_word)
                report_mismatch("mem_write_word", got.mem_write_word, want.mem_write_word);
            if (got.transfer_end !== want.transfer_end)
                report_mismatch("transfer_end", 32'(got.transfer_end),
                                32'(want.transfer_end));
        endtask
    endclass

    // Every block input starts at a known value.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [1:0]  req_type    = '0;
    logic [1:0]  reg_index   = '0;
    logic [31:0] write_value = '0;
    logic [31:0] push_bytes  = '0;
    logic [2:0]  push_count  = '0;
    logic        out_stall   = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        mem_write_valid;
    logic [31:0] mem_write_addr;
    logic [31:0] mem_write_word;
    logic        transfer_end;

    rx_channel_scoreboard sb = new();

    // Stimulus control shared with the result side. While steady is set
    // neither side idles; squeeze_req asks the result side for one long
    // hold-off so the block fills up and stalls its input.
    bit         steady      = 1'b0;
    bit         squeeze_req = 1'b0;
    int         beats_sent  = 0;

    dma_rx_channel_with_transfer_queue_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .reg_index       (reg_index),
        .write_value     (write_value),
        .push_bytes      (push_bytes),
        .push_count      (push_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .read_value      (read_value),
        .mem_write_valid (mem_write_valid),
        .mem_write_addr  (mem_write_addr),
        .mem_write_word  (mem_write_word),
        .transfer_end    (transfer_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one request beat. It is entered and left just after a falling
    // edge, so in_valid gets exactly one assignment in each time step: the
    // next call either raises it again with a new payload or lowers it while
    // the bench idles.
    task automatic send_beat(input logic [1:0] rt, input logic [1:0] ri,
                             input logic [31:0] wv, input logic [31:0] pb,
                             input logic [2:0] pc);
        while (!steady && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rt;
        reg_index   <= ri;
        write_value <= wv;
        push_bytes  <= pb;
        push_count  <= pc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(rt, ri, wv, pb, pc);
        beats_sent++;
        @(negedge clk);
    endtask

    // Unused payload fields carry random bits so every input bit toggles.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        send_beat(REQ_WRITE, idx, val, $urandom, 3'($urandom));
    endtask

    task automatic read_reg(input logic [1:0] idx);
        send_beat(REQ_READ, idx, $urandom, $urandom, 3'($urandom));
    endtask

    task automatic push_beat(input logic [31:0] bytes, input logic [2:0] cnt);
        send_beat(REQ_PUSH, 2'($urandom), $urandom, bytes, cnt);
    endtask

    // One well-formed transfer, sometimes two queued back to back, fed with pushes
    // that fit the packing word until the channel goes idle or after 400 passes.
    // A few pushes have random counts and a few reads are mixed in.
    task automatic run_transfer();
        logic [31:0] addr;
        logic [31:0] cfg_val;
        int          len;
        int          guard;
        int          room;
        addr = ($urandom_range(9) == 0) ? (32'hFFFF_FF00 | $urandom_range(255)) : $urandom;
        len  = ($urandom_range(49) == 0) ? $urandom_range(1024) : $urandom_range(48);
        write_reg(REG_START, addr);
        // The bits above the size field are dropped by the register.
        write_reg(REG_SIZE, 32'(len) | ($urandom << SIZE_BITS));
        cfg_val = $urandom;
        cfg_val[CFG_CLR_BIT] = 1'b0;
        cfg_val[CFG_EN_BIT]  = 1'b1;
        write_reg(REG_CFG, cfg_val);
        if ($urandom_range(3) == 0)
        begin
            write_reg(REG_START, $urandom);
            write_reg(REG_SIZE, $urandom_range(24));
            cfg_val = $urandom;
            cfg_val[CFG_CLR_BIT] = 1'b0;
            cfg_val[CFG_EN_BIT]  = 1'b1;
            write_reg(REG_CFG, cfg_val);
        end
        guard = 0;
        while (sb.active && guard < 400)
        begin
            guard++;
            room = int'(WORD_BYTES) - sb.pack_idx;
            case ($urandom_range(19))
                0:       push_beat($urandom, 3'($urandom));
                1:       read_reg(2'($urandom_range(3)));
                default: push_beat($urandom, 3'($urandom_range(room, 1)));
            endcase
        end
    endtask

    // A fully random beat. A config write that would enqueue is turned into
    // a plain field update, since its size register may hold a huge value.
    task automatic send_noise();
        logic [1:0]  rt;
        logic [1:0]  ri;
        logic [31:0] wv;
        rt = 2'($urandom);
        ri = 2'($urandom);
        wv = $urandom;
        if (rt == REQ_WRITE && ri == REG_CFG && !wv[CFG_CLR_BIT])
            wv[CFG_EN_BIT] = 1'b0;
        send_beat(rt, ri, wv, $urandom, 3'($urandom));
    endtask

    // Result side: random stalls, none while steady, and one long hold-off when asked for.
    initial
    begin : result_side
        int  hold_left;
        bit  squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeezed)
            begin
                squeezed  = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 14);
        end
    end

    // A result beat is taken at every rising edge where it is valid and not
    // stalled; values are read before the block updates them.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status          = status;
            got.read_value      = read_value;
            got.mem_write_valid = mem_write_valid;
            got.mem_write_addr  = mem_write_addr;
            got.mem_write_word  = mem_write_word;
            got.transfer_end    = transfer_end;
            sb.check_result(got);
        end
    end

    initial
    begin : stimulus
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Illegal accesses and a push with no transfer first.
        read_reg(REG_CFG);
        read_reg(REG_BAD);
        write_reg(REG_BAD, 32'hFFFF_FFFF);
        send_beat(REQ_BAD, REG_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        push_beat(32'h1122_3344, 3'd4);

        // Register extremes; the size reads back masked to its width.
        write_reg(REG_START, 32'hFFFF_FFFF);
        write_reg(REG_SIZE, 32'hFFFF_FFFF);
        read_reg(REG_SIZE);

        // A six-byte transfer near the top of memory, so the address wraps.
        write_reg(REG_START, 32'hFFFF_FFFA);
        write_reg(REG_SIZE, 32'd6);
        // Clear with enable also set: fields stored, nothing queued.
        write_reg(REG_CFG, 32'h0000_0057);
        write_reg(REG_CFG, 32'h0000_0010);
        write_reg(REG_CFG, 32'h0000_0010);
        // Both slots busy now, so this enable is ignored.
        write_reg(REG_CFG, 32'h0000_0010);
        read_reg(REG_CFG);

        // Empty push, oversized push, then a push that overflows the word.
        push_beat(32'hDEAD_BEEF, 3'd0);
        push_beat(32'hDEAD_BEEF, 3'd7);
        push_beat(32'h00AA_BBCC, 3'd3);
        push_beat(32'h0000_EEDD, 3'd2);
        push_beat(32'h0000_0011, 3'd1);
        // Ends the first transfer; the upper bytes of the word are stale.
        push_beat(32'h0000_2233, 3'd2);

        // Queue a zero-size transfer behind the second one.
        write_reg(REG_SIZE, 32'd0);
        write_reg(REG_CFG, 32'h0000_0010);
        push_beat(32'h4455_6677, 3'd4);
        push_beat(32'h0000_8899, 3'd2);
        push_beat(32'h0000_00AB, 3'd1);

        // Random part, with one long receiver hold-off at its start and a
        // stretch in the middle where neither side idles.
        squeeze_req = 1'b1;
        while (beats_sent < BEAT_TARGET)
        begin
            steady = (beats_sent >= 400 && beats_sent < 600);
            if ($urandom_range(99) < 80)
                run_transfer();
            else
                send_noise();
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
